/* design/bple_pkg.sv */
// shared codes, defaults and controller/datapath interface structs for the
// breakpoint envelope block; no dependencies
package bple_pkg;

   localparam int unsigned MAX_POINTS_DEFAULT = 16;

   // request codes
   localparam logic [1:0] REQ_TICK    = 2'd0;
   localparam logic [1:0] REQ_ADD     = 2'd1;
   localparam logic [1:0] REQ_RESTART = 2'd2;
   localparam logic [1:0] REQ_UNUSED  = 2'd3;

   // result status codes
   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_EMPTY  = 3'd1;
   localparam logic [2:0] ST_BEFORE = 3'd2;
   localparam logic [2:0] ST_DUP    = 3'd3;
   localparam logic [2:0] ST_FULL   = 3'd4;

   // datapath operations
   localparam logic [3:0] OP_NOP        = 4'd0;
   localparam logic [3:0] OP_LATCH      = 4'd1;
   localparam logic [3:0] OP_RD_IDX     = 4'd2;
   localparam logic [3:0] OP_SCAN       = 4'd3;
   localparam logic [3:0] OP_SHIFT_INIT = 4'd4;
   localparam logic [3:0] OP_RD_PREV    = 4'd5;
   localparam logic [3:0] OP_WR_SHIFT   = 4'd6;
   localparam logic [3:0] OP_INSERT     = 4'd7;
   localparam logic [3:0] OP_RD_SEG     = 4'd8;
   localparam logic [3:0] OP_CAP0       = 4'd9;
   localparam logic [3:0] OP_CAP1       = 4'd10;
   localparam logic [3:0] OP_HOLD       = 4'd11;
   localparam logic [3:0] OP_CLAMP      = 4'd12;
   localparam logic [3:0] OP_MD_START   = 4'd13;
   localparam logic [3:0] OP_INTERP     = 4'd14;
   localparam logic [3:0] OP_RESTART    = 4'd15;

   typedef struct packed {
      logic [3:0] op;
      logic       rsp_fire;
      logic [2:0] rsp_status;
      logic       rsp_use_val;
   } bple_cmd_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic       count_zero;
      logic       dup;
      logic       full;
      logic       scan_more;
      logic       shift_more;
      logic       at_point;
      logic       past_point;
      logic       last_seg;
      logic       el_ge_span;
      logic       md_done;
   } bple_stat_type;

endpackage

/* design/bple_muldiv.sv */
// iterative unit: quot = (mag * el) / span, shift-add multiply then restoring divide
// depends on nothing outside this file
module bple_muldiv (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] mag,
   input  logic [31:0] el,
   input  logic [31:0] span,
   output logic        done,
   output logic [31:0] quot
);

   localparam logic [6:0] MUL_STEPS = 7'd32;
   localparam logic [6:0] LAST_STEP = 7'd95;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [31:0] mcand_ff, mcand_in;
   logic [31:0] mplier_ff, mplier_in;
   logic [31:0] span_ff, span_in;
   logic [63:0] prod_ff, prod_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quot_ff, quot_in;
   logic [32:0] rem2;
   logic [32:0] rem_diff;

   always_comb begin
      rem2     = {rem_ff, prod_ff[63]};
      rem_diff = rem2 - {1'b0, span_ff};
   end

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      span_in   = span_ff;
      prod_in   = prod_ff;
      rem_in    = rem_ff;
      quot_in   = quot_ff;
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         mcand_in  = mag;
         mplier_in = el;
         span_in   = span;
         prod_in   = '0;
         rem_in    = '0;
         quot_in   = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff < MUL_STEPS) begin
            prod_in   = {prod_ff[62:0], 1'b0} + (mplier_ff[31] ? {32'd0, mcand_ff} : 64'd0);
            mplier_in = {mplier_ff[30:0], 1'b0};
         end else begin
            prod_in = {prod_ff[62:0], 1'b0};
            if (!rem_diff[32]) begin
               rem_in  = rem_diff[31:0];
               quot_in = {quot_ff[30:0], 1'b1};
            end else begin
               rem_in  = rem2[31:0];
               quot_in = {quot_ff[30:0], 1'b0};
            end
            if (cnt_ff == LAST_STEP) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff    <= cnt_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      span_ff   <= span_in;
      prod_ff   <= prod_in;
      rem_ff    <= rem_in;
      quot_ff   <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

/* design/bple_dpath.sv */
// datapath: breakpoint memory, count/segment/time state, interpolation and result
// registers; uses bple_pkg and bple_muldiv
module bple_dpath
   import bple_pkg::*;
#(
   parameter int unsigned MAX_POINTS = MAX_POINTS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  bple_cmd_type  cmd,
   output bple_stat_type stat,
   input  logic [1:0]    req_type,
   input  logic [31:0]   req_point_time,
   input  logic signed [31:0] req_point_value,
   output logic          rsp_strobe,
   output logic signed [31:0] rsp_sample_value,
   output logic [2:0]    rsp_status
);

   localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int unsigned CW = $clog2(MAX_POINTS + 1);

   logic [31:0] time_mem [MAX_POINTS];
   logic [31:0] value_mem [MAX_POINTS];

   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] seg_ff, seg_in;
   logic [31:0]   time_ff, time_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic          dup_ff, dup_in;
   logic [1:0]    rtype_ff;
   logic [31:0]   rt_ff, rv_ff;
   logic [31:0]   t0_ff, v0_ff, t1_ff, v1_ff;
   logic [31:0]   rd_time_ff, rd_val_ff;
   logic          rsp_strobe_ff;
   logic [31:0]   rsp_value_ff;
   logic [2:0]    rsp_status_ff;

   logic [CW-1:0] segc_w, segn_w, idx_prev;
   logic [AW-1:0] rd_addr;
   logic          rd_en;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [31:0]   wr_time, wr_val;
   logic [31:0]   time_inc, span, el, mag, quot, interp, val_now;
   logic [32:0]   dv;
   logic          md_done;

   // segment actually used: clamped to the last stored point
   always_comb begin
      segc_w   = (CW'(seg_ff) >= count_ff) ? (count_ff - CW'(1)) : CW'(seg_ff);
      segn_w   = segc_w + CW'(1);
      idx_prev = idx_ff - CW'(1);
      time_inc = (time_ff == 32'hFFFF_FFFF) ? time_ff : (time_ff + 32'd1);
      span     = t1_ff - t0_ff;
      el       = time_ff - t0_ff;
      dv       = {v1_ff[31], v1_ff} - {v0_ff[31], v0_ff};
      mag      = dv[32] ? 32'(33'd0 - dv) : dv[31:0];
      interp   = dv[32] ? (v0_ff - quot) : (v0_ff + quot);
   end

   bple_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .start (cmd.op == OP_MD_START),
      .mag   (mag),
      .el    (el),
      .span  (span),
      .done  (md_done),
      .quot  (quot)
   );

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = idx_ff[AW-1:0];
      wr_en   = 1'b0;
      wr_addr = idx_ff[AW-1:0];
      wr_time = rd_time_ff;
      wr_val  = rd_val_ff;
      case (cmd.op)
         OP_RD_IDX: begin
            rd_en = 1'b1;
         end
         OP_RD_PREV: begin
            rd_en   = 1'b1;
            rd_addr = idx_prev[AW-1:0];
         end
         OP_RD_SEG: begin
            rd_en   = 1'b1;
            rd_addr = segc_w[AW-1:0];
         end
         OP_CAP0: begin
            rd_en   = 1'b1;
            rd_addr = segn_w[AW-1:0];
         end
         OP_WR_SHIFT: begin
            wr_en = 1'b1;
         end
         OP_INSERT: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff[AW-1:0];
            wr_time = rt_ff;
            wr_val  = rv_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         time_mem[wr_addr]  <= wr_time;
         value_mem[wr_addr] <= wr_val;
      end
      if (rd_en) begin
         rd_time_ff <= time_mem[rd_addr];
         rd_val_ff  <= value_mem[rd_addr];
      end
   end

   always_comb begin
      count_in = count_ff;
      seg_in   = seg_ff;
      time_in  = time_ff;
      idx_in   = idx_ff;
      pos_in   = pos_ff;
      dup_in   = dup_ff;
      case (cmd.op)
         OP_LATCH: begin
            idx_in = '0;
            pos_in = '0;
            dup_in = 1'b0;
         end
         OP_SCAN: begin
            if (rd_time_ff == rt_ff) dup_in = 1'b1;
            if (rd_time_ff < rt_ff) pos_in = pos_ff + CW'(1);
            idx_in = idx_ff + CW'(1);
         end
         OP_SHIFT_INIT: begin
            idx_in = count_ff;
         end
         OP_WR_SHIFT: begin
            idx_in = idx_prev;
         end
         OP_INSERT: begin
            count_in = count_ff + CW'(1);
            seg_in   = '0;
            time_in  = '0;
         end
         OP_HOLD: begin
            time_in = time_inc;
         end
         OP_CLAMP, OP_INTERP: begin
            time_in = time_inc;
            seg_in  = (time_inc >= t1_ff) ? segn_w[AW-1:0] : segc_w[AW-1:0];
         end
         OP_RESTART: begin
            seg_in  = '0;
            time_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      case (cmd.op)
         OP_HOLD:   val_now = v0_ff;
         OP_CLAMP:  val_now = v1_ff;
         OP_INTERP: val_now = interp;
         default:   val_now = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         seg_ff        <= '0;
         time_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         seg_ff        <= seg_in;
         time_ff       <= time_in;
         rsp_strobe_ff <= cmd.rsp_fire;
      end
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      dup_ff <= dup_in;
      if (cmd.op == OP_LATCH) begin
         rtype_ff <= req_type;
         rt_ff    <= req_point_time;
         rv_ff    <= req_point_value;
      end
      if (cmd.op == OP_CAP0) begin
         t0_ff <= rd_time_ff;
         v0_ff <= rd_val_ff;
      end
      if (cmd.op == OP_CAP1) begin
         t1_ff <= rd_time_ff;
         v1_ff <= rd_val_ff;
      end
      if (cmd.rsp_fire) begin
         rsp_value_ff  <= cmd.rsp_use_val ? val_now : 32'd0;
         rsp_status_ff <= cmd.rsp_status;
      end
   end

   always_comb begin
      stat.req_type   = rtype_ff;
      stat.count_zero = (count_ff == '0);
      stat.dup        = dup_ff;
      stat.full       = (count_ff == CW'(MAX_POINTS));
      stat.scan_more  = (idx_ff < count_ff);
      stat.shift_more = (idx_ff > pos_ff);
      stat.at_point   = (time_ff == t0_ff);
      stat.past_point = (time_ff > t0_ff);
      stat.last_seg   = (segn_w >= count_ff);
      stat.el_ge_span = (el >= span);
      stat.md_done    = md_done;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_sample_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_POINTS))
      else $error("point count beyond table size");

   a_seg_in_table: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) || (CW'(seg_ff) < count_ff))
      else $error("segment index past stored points");

   a_strobe_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("result beats back to back");

   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && (rsp_status_ff != ST_OK)) |-> (rsp_value_ff == 32'd0))
      else $error("flagged result carries a value");
`endif

endmodule

/* design/bple_ctrl.sv */
// controller state machine: sequences scan, insert shift and tick evaluation
// through datapath commands; uses bple_pkg
module bple_ctrl
   import bple_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  bple_stat_type stat,
   output bple_cmd_type  cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_SRD    = 4'd2;
   localparam logic [3:0] S_SCMP   = 4'd3;
   localparam logic [3:0] S_ACHK   = 4'd4;
   localparam logic [3:0] S_SHRD   = 4'd5;
   localparam logic [3:0] S_SHWR   = 4'd6;
   localparam logic [3:0] S_TCAP0  = 4'd7;
   localparam logic [3:0] S_TEVAL  = 4'd8;
   localparam logic [3:0] S_TCMP   = 4'd9;
   localparam logic [3:0] S_TMDW   = 4'd10;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in        = state_ff;
      cmd.op          = OP_NOP;
      cmd.rsp_fire    = 1'b0;
      cmd.rsp_status  = ST_OK;
      cmd.rsp_use_val = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op   = OP_LATCH;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.req_type)
               REQ_TICK: begin
                  if (stat.count_zero) begin
                     cmd.rsp_fire   = 1'b1;
                     cmd.rsp_status = ST_EMPTY;
                     state_in       = S_IDLE;
                  end else begin
                     cmd.op   = OP_RD_SEG;
                     state_in = S_TCAP0;
                  end
               end
               REQ_ADD: begin
                  state_in = S_SRD;
               end
               REQ_RESTART: begin
                  cmd.op       = OP_RESTART;
                  cmd.rsp_fire = 1'b1;
                  state_in     = S_IDLE;
               end
               default: begin
                  cmd.rsp_fire = 1'b1;
                  state_in     = S_IDLE;
               end
            endcase
         end
         S_SRD: begin
            if (stat.scan_more) begin
               cmd.op   = OP_RD_IDX;
               state_in = S_SCMP;
            end else begin
               state_in = S_ACHK;
            end
         end
         S_SCMP: begin
            cmd.op   = OP_SCAN;
            state_in = S_SRD;
         end
         S_ACHK: begin
            if (stat.dup) begin
               cmd.rsp_fire   = 1'b1;
               cmd.rsp_status = ST_DUP;
               state_in       = S_IDLE;
            end else if (stat.full) begin
               cmd.rsp_fire   = 1'b1;
               cmd.rsp_status = ST_FULL;
               state_in       = S_IDLE;
            end else begin
               cmd.op   = OP_SHIFT_INIT;
               state_in = S_SHRD;
            end
         end
         S_SHRD: begin
            if (stat.shift_more) begin
               cmd.op   = OP_RD_PREV;
               state_in = S_SHWR;
            end else begin
               cmd.op       = OP_INSERT;
               cmd.rsp_fire = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_SHWR: begin
            cmd.op   = OP_WR_SHIFT;
            state_in = S_SHRD;
         end
         S_TCAP0: begin
            cmd.op   = OP_CAP0;
            state_in = S_TEVAL;
         end
         S_TEVAL: begin
            if (stat.at_point || (stat.past_point && stat.last_seg)) begin
               cmd.op          = OP_HOLD;
               cmd.rsp_fire    = 1'b1;
               cmd.rsp_use_val = 1'b1;
               state_in        = S_IDLE;
            end else if (stat.past_point) begin
               cmd.op   = OP_CAP1;
               state_in = S_TCMP;
            end else begin
               cmd.rsp_fire   = 1'b1;
               cmd.rsp_status = ST_BEFORE;
               state_in       = S_IDLE;
            end
         end
         S_TCMP: begin
            if (stat.el_ge_span) begin
               cmd.op          = OP_CLAMP;
               cmd.rsp_fire    = 1'b1;
               cmd.rsp_use_val = 1'b1;
               state_in        = S_IDLE;
            end else begin
               cmd.op   = OP_MD_START;
               state_in = S_TMDW;
            end
         end
         S_TMDW: begin
            if (stat.md_done) begin
               cmd.op          = OP_INTERP;
               cmd.rsp_fire    = 1'b1;
               cmd.rsp_use_val = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

/* design/breakpoint_linear_envelope.sv */
// one request at a time; a restart, an unused code or a tick on an empty table is answered
// from decode; held, early and clamped ticks read the table first; an interpolated tick
// also runs the multiply then divide unit, one bit per cycle; an add scans every stored
// point through one memory port, then an insert shifts the later points up; start can be
// taken at the edge that takes the result
// synchronous reset empties the table and zeroes time and segment
module breakpoint_linear_envelope
   import bple_pkg::*;
#(
   parameter int unsigned MAX_POINTS = MAX_POINTS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_type,
   input  logic [31:0]        req_point_time,
   input  logic signed [31:0] req_point_value,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_sample_value,
   output logic [2:0]         rsp_status
);

   bple_cmd_type  cmd;
   bple_stat_type stat;

   bple_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   bple_dpath #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_type         (req_type),
      .req_point_time   (req_point_time),
      .req_point_value  (req_point_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_sample_value (rsp_sample_value),
      .rsp_status       (rsp_status)
   );

endmodule

/* dv/breakpoint_linear_envelope_checker.sv */
// checker for the breakpoint envelope: watches request and result beats,
// predicts each result with its own table model; depends on bple_pkg
module breakpoint_linear_envelope_checker
   import bple_pkg::*;
#(
   parameter int unsigned MAX_POINTS = MAX_POINTS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [1:0]         req_type,
   input  logic [31:0]        req_point_time,
   input  logic signed [31:0] req_point_value,
   input  logic               rsp_strobe,
   input  logic signed [31:0] rsp_sample_value,
   input  logic [2:0]         rsp_status,
   output int                 fail_count,
   output int                 pending_count,
   output int                 rsp_count,
   output int                 interp_count
);

   typedef struct packed {
      logic [31:0] value;
      logic [2:0]  status;
   } env_result_type;

   logic [31:0] bp_time  [MAX_POINTS];
   logic [31:0] bp_value [MAX_POINTS];
   int unsigned bp_count;
   int unsigned seg_idx;
   logic [31:0] now_time;
   env_result_type expected_q[$];

   function automatic logic [31:0] lerp(int unsigned seg, logic [31:0] t);
      logic [63:0] span, el, mag, q;
      logic signed [63:0] v0, v1, dv, r;
      span = {32'd0, bp_time[seg + 1]} - {32'd0, bp_time[seg]};
      el   = {32'd0, t} - {32'd0, bp_time[seg]};
      v0   = {{32{bp_value[seg][31]}}, bp_value[seg]};
      v1   = {{32{bp_value[seg + 1][31]}}, bp_value[seg + 1]};
      dv   = v1 - v0;
      if (span == 0 || el >= span) return v1[31:0];
      mag = (dv < 0) ? -dv : dv;
      q = (mag * el) / span;
      r = (dv < 0) ? v0 - $signed(q) : v0 + $signed(q);
      return r[31:0];
   endfunction

   task automatic envelope_step(input logic [1:0] kind, input logic [31:0] t,
                                input logic [31:0] v);
      env_result_type res;
      int unsigned seg, pos;
      logic dup;
      res = '0;
      if (kind == REQ_TICK) begin
         seg = seg_idx;
         if (bp_count == 0) res.status = ST_EMPTY;
         else begin
            if (seg >= bp_count) seg = bp_count - 1;
            if (now_time == bp_time[seg] ||
                (now_time >= bp_time[seg] && seg + 1 >= bp_count)) begin
               res.value = bp_value[seg];
               if (now_time != 32'hFFFF_FFFF) now_time++;
            end else if (now_time > bp_time[seg]) begin
               res.value = lerp(seg, now_time);
               interp_count++;
               if (now_time != 32'hFFFF_FFFF) now_time++;
               if (now_time >= bp_time[seg + 1]) seg++;
               seg_idx = seg;
            end else res.status = ST_BEFORE;
         end
      end else if (kind == REQ_ADD) begin
         dup = 1'b0;
         for (int i = 0; i < bp_count; i++) if (bp_time[i] == t) dup = 1'b1;
         if (dup) res.status = ST_DUP;
         else if (bp_count >= MAX_POINTS) res.status = ST_FULL;
         else begin
            pos = 0;
            while (pos < bp_count && bp_time[pos] < t) pos++;
            for (int i = bp_count; i > pos; i--) begin
               bp_time[i]  = bp_time[i - 1];
               bp_value[i] = bp_value[i - 1];
            end
            bp_time[pos]  = t;
            bp_value[pos] = v;
            bp_count++;
            now_time = '0;
            seg_idx  = 0;
         end
      end else if (kind == REQ_RESTART) begin
         now_time = '0;
         seg_idx  = 0;
      end
      expected_q = {expected_q, res};
   endtask

   always @(posedge clock) begin
      env_result_type exp_res;
      if (reset) begin
         bp_count = 0;
         seg_idx  = 0;
         now_time = '0;
         expected_q.delete();
         fail_count   <= 0;
         rsp_count    <= 0;
         interp_count = 0;
      end else begin
         // result before request: a same-edge beat cannot answer this request
         if (rsp_strobe) begin
            rsp_count <= rsp_count + 1;
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result value=%h status=%0d", $time,
                        rsp_sample_value, rsp_status);
               fail_count <= fail_count + 1;
            end else begin
               exp_res = expected_q.pop_front();
               if (exp_res.value !== rsp_sample_value || exp_res.status !== rsp_status) begin
                  $display("%0t: mismatch expected value=%h status=%0d actual value=%h status=%0d",
                           $time, exp_res.value, exp_res.status, rsp_sample_value, rsp_status);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy) envelope_step(req_type, req_point_time, req_point_value);
      end
      pending_count <= expected_q.size();
   end

endmodule

/* dv/tb_breakpoint_linear_envelope.sv */
// testbench top for breakpoint_linear_envelope: drives requests with random gaps
// and gives the verdict; depends on bple_pkg and the checker module
module tb_breakpoint_linear_envelope;
   import bple_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_type = REQ_TICK;
   logic [31:0]        req_point_time = '0;
   logic signed [31:0] req_point_value = '0;
   logic               rsp_strobe;
   logic signed [31:0] rsp_sample_value;
   logic [2:0]         rsp_status;
   int fail_count, pending_count, rsp_count, interp_count;
   int idle_cycles;
   int sent_count;

   always #5 clock = ~clock;

   breakpoint_linear_envelope DUT (.*);

   breakpoint_linear_envelope_checker #(.MAX_POINTS(MAX_POINTS_DEFAULT)) u_checker (.*);

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("watchdog expired");
         $display("FAILURE");
         $finish;
      end
   end

   // start drops only for a nonzero gap, so a zero gap keeps it high
   task automatic random_gap();
      int n;
      n = $urandom_range(0, 99);
      if (n < 40) n = 0;
      else if (n < 90) n = $urandom_range(1, 4);
      else n = $urandom_range(20, 150);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // one beat: hold start until accepted
   task automatic send(input logic [1:0] kind, input logic [31:0] t,
                       input logic [31:0] v);
      random_gap();
      start           <= 1'b1;
      req_type        <= kind;
      req_point_time  <= t;
      req_point_value <= v;
      do @(posedge clock); while (busy);
      sent_count++;
   endtask

   task automatic rand_value(output logic [31:0] v);
      case ($urandom_range(0, 3))
         0: v = 32'h8000_0000;
         1: v = 32'h7FFF_FFFF;
         default: v = $urandom();
      endcase
   endtask

   initial begin
      logic [31:0] v;
      logic [31:0] t;
      int n;
      sent_count = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: empty table, extremes, before first point, duplicate, full
      send(REQ_TICK, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      send(REQ_UNUSED, '0, '0);
      send(REQ_ADD, 32'd3, 32'h8000_0000);
      send(REQ_TICK, '0, '0);
      send(REQ_ADD, 32'd6, 32'h7FFF_FFFF);
      repeat (8) send(REQ_TICK, '0, '0);
      send(REQ_ADD, 32'd3, 32'd5);
      send(REQ_RESTART, '0, '0);
      send(REQ_ADD, 32'hFFFF_FFFF, 32'h1234_5678);
      send(REQ_ADD, 32'd0, 32'd0);
      repeat (5) send(REQ_TICK, '0, '0);
      for (int i = 0; i < 14; i++) send(REQ_ADD, 32'd100 + i * 7, $urandom());
      send(REQ_ADD, 32'd9, 32'd1);
      for (int i = 0; i < 120; i++) send(REQ_TICK, '0, '0);
      // random phases: restart with a fresh table by filling then resetting is not
      // possible; the table stays as the directed part filled it, so random adds are rejected
      while (sent_count < 430) begin
         n = $urandom_range(0, 99);
         if (n < 70) send(REQ_TICK, $urandom(), $urandom());
         else if (n < 85) begin
            rand_value(v);
            t = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 400);
            send(REQ_ADD, t, v);
         end else if (n < 95) send(REQ_RESTART, $urandom(), $urandom());
         else send(REQ_UNUSED, $urandom(), $urandom());
      end
      start <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("covered %0d requests, %0d results, %0d interpolated ticks", sent_count,
               rsp_count, interp_count);
      if (fail_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
